### sv/powt_pkg.sv
// ----------------------------------------------------------------------------
// powt_pkg
// Shared widths, defaults and the stored record layout for the priority
// order wait time scheduler.
// ----------------------------------------------------------------------------
package powt_pkg;

   localparam int MAX_PROCS_DEF = 16;

   localparam int ID_W    = 8;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int TIME_W  = 20;
   localparam int TOTAL_W = 24;
   localparam int FRAC_W  = 8;
   localparam int AVG_W   = 28;
   localparam int DIVD_W  = TOTAL_W + FRAC_W;

   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
      logic [ID_W-1:0]    id;
   } rec_type;

endpackage

### sv/priority_order_wait_times.sv
// ----------------------------------------------------------------------------
// priority_order_wait_times
// Nonpreemptive priority scheduler: collects process records, orders them
// stably by priority and reports wait and turnaround per process, with the
// averages on the final result.
//
//  channel   handshake              payload
//  request   start & !busy          req_process_id, req_burst_time,
//                                   req_priority_req, req_last
//  response  rsp_strobe (1 cycle)   rsp_out_*, rsp_wait_time, rsp_turnaround_time,
//                                   rsp_avg_wait, rsp_avg_turnaround, rsp_final_res
//
// A record without last is stored while the store has room. A closing record
// starts the schedule: per result a selection scan over the n stored records
// through the store read port and one emit state, then two divisions on the
// shared divider, one for each average.
// busy is high meanwhile.
// Synchronous reset empties the store. Results cannot be stalled.
// ----------------------------------------------------------------------------
module priority_order_wait_times import powt_pkg::*; #(
   parameter int MAX_PROCS = MAX_PROCS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [ID_W-1:0]    req_process_id,
   input  logic [BURST_W-1:0] req_burst_time,
   input  logic [PRIO_W-1:0]  req_priority_req,
   input  logic               req_last,
   output logic               rsp_strobe,
   output logic [ID_W-1:0]    rsp_out_process_id,
   output logic [PRIO_W-1:0]  rsp_out_priority,
   output logic [BURST_W-1:0] rsp_out_burst,
   output logic [TIME_W-1:0]  rsp_wait_time,
   output logic [TIME_W-1:0]  rsp_turnaround_time,
   output logic [AVG_W-1:0]   rsp_avg_wait,
   output logic [AVG_W-1:0]   rsp_avg_turnaround,
   output logic               rsp_final_res
);

   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

   typedef enum logic [2:0] {
      ST_LOAD, ST_SCAN, ST_EMIT, ST_DIV_W, ST_DIV_T
   } state_type;

   state_type          state_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      n_ff;
   logic [CW-1:0]      scan_cnt_ff;
   logic [CW-1:0]      out_pos_ff;
   logic               pend_ff;
   logic [IW-1:0]      pend_idx_ff;
   logic               best_valid_ff;
   logic [IW-1:0]      best_idx_ff;
   rec_type            best_rec_ff;
   logic [MAX_PROCS-1:0] used_ff;
   logic [TIME_W-1:0]  wait_ff;
   logic [TOTAL_W-1:0] wait_total_ff;
   logic [TOTAL_W-1:0] tat_total_ff;
   logic               div_start_ff;

   logic               strobe_ff;
   logic [ID_W-1:0]    id_ff;
   logic [PRIO_W-1:0]  prio_ff;
   logic [BURST_W-1:0] burst_ff;
   logic [TIME_W-1:0]  wait_out_ff;
   logic [TIME_W-1:0]  tat_out_ff;
   logic [AVG_W-1:0]   avg_w_ff;
   logic [AVG_W-1:0]   avg_t_ff;
   logic               final_ff;

   rec_type            mem [MAX_PROCS];
   rec_type            rd_data_ff;

   logic               accept;
   logic               wr_en;
   logic [CW-1:0]      n_in;
   logic [TIME_W-1:0]  tat_in;
   logic [TOTAL_W-1:0] wait_total_in;
   logic [TOTAL_W-1:0] tat_total_in;
   logic [DIVD_W-1:0]  div_dividend;
   logic               div_done;
   logic [DIVD_W-1:0]  div_quotient;

   assign accept = start && (state_ff == ST_LOAD);
   assign wr_en  = accept && (count_ff < CW'(MAX_PROCS));
   assign n_in   = wr_en ? CW'(count_ff + 1'b1) : count_ff;

   assign tat_in        = TIME_W'(wait_ff + TIME_W'(best_rec_ff.burst));
   assign wait_total_in = TOTAL_W'(wait_total_ff + TOTAL_W'(wait_ff));
   assign tat_total_in  = TOTAL_W'(tat_total_ff + TOTAL_W'(tat_in));

   assign div_dividend = (state_ff == ST_DIV_T) ? {tat_total_ff, FRAC_W'(0)}
                                                : {wait_total_ff, FRAC_W'(0)};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IW-1:0]] <= rec_type'{prio: req_priority_req,
                                            burst: req_burst_time,
                                            id: req_process_id};
      end
      rd_data_ff <= mem[scan_cnt_ff[IW-1:0]];
   end

   powt_div #(
      .CNT_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         best_valid_ff <= 1'b0;
         div_start_ff  <= 1'b0;
         strobe_ff     <= 1'b0;
         wait_total_ff <= '0;
         tat_total_ff  <= '0;
      end else begin
         strobe_ff    <= 1'b0;
         div_start_ff <= 1'b0;
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  count_ff <= n_in;
                  if (req_last) begin
                     n_ff          <= n_in;
                     scan_cnt_ff   <= '0;
                     out_pos_ff    <= '0;
                     pend_ff       <= 1'b0;
                     best_valid_ff <= 1'b0;
                     used_ff       <= '0;
                     wait_ff       <= '0;
                     wait_total_ff <= '0;
                     tat_total_ff  <= '0;
                     state_ff      <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (scan_cnt_ff != n_ff) begin
                  scan_cnt_ff <= scan_cnt_ff + 1'b1;
                  pend_ff     <= 1'b1;
                  pend_idx_ff <= scan_cnt_ff[IW-1:0];
               end else begin
                  pend_ff <= 1'b0;
               end
               // strict compare keeps the earliest record among equal priorities
               if (pend_ff && !used_ff[pend_idx_ff] &&
                   (!best_valid_ff || rd_data_ff.prio < best_rec_ff.prio)) begin
                  best_valid_ff <= 1'b1;
                  best_idx_ff   <= pend_idx_ff;
                  best_rec_ff   <= rd_data_ff;
               end
               if (scan_cnt_ff == n_ff && !pend_ff) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               used_ff[best_idx_ff] <= 1'b1;
               wait_ff       <= tat_in;
               wait_total_ff <= wait_total_in;
               tat_total_ff  <= tat_total_in;
               id_ff         <= best_rec_ff.id;
               prio_ff       <= best_rec_ff.prio;
               burst_ff      <= best_rec_ff.burst;
               wait_out_ff   <= wait_ff;
               tat_out_ff    <= tat_in;
               avg_w_ff      <= '0;
               avg_t_ff      <= '0;
               final_ff      <= 1'b0;
               if (out_pos_ff != CW'(n_ff - 1'b1)) begin
                  strobe_ff     <= 1'b1;
                  out_pos_ff    <= out_pos_ff + 1'b1;
                  scan_cnt_ff   <= '0;
                  best_valid_ff <= 1'b0;
                  state_ff      <= ST_SCAN;
               end else begin
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV_W;
               end
            end
            ST_DIV_W: begin
               if (div_done) begin
                  avg_w_ff     <= div_quotient[AVG_W-1:0];
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV_T;
               end
            end
            ST_DIV_T: begin
               if (div_done) begin
                  avg_t_ff  <= div_quotient[AVG_W-1:0];
                  final_ff  <= 1'b1;
                  strobe_ff <= 1'b1;
                  count_ff  <= '0;
                  state_ff  <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign busy                = (state_ff != ST_LOAD);
   assign rsp_strobe          = strobe_ff;
   assign rsp_out_process_id  = id_ff;
   assign rsp_out_priority    = prio_ff;
   assign rsp_out_burst       = burst_ff;
   assign rsp_wait_time       = wait_out_ff;
   assign rsp_turnaround_time = tat_out_ff;
   assign rsp_avg_wait        = avg_w_ff;
   assign rsp_avg_turnaround  = avg_t_ff;
   assign rsp_final_res       = final_ff;

`ifndef SYNTHESIS
   a_tat_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_turnaround_time == TIME_W'(rsp_wait_time + TIME_W'(rsp_out_burst)))
      else $error("turnaround differs from wait plus burst");

   a_final_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_final_res |-> count_ff == '0 && !busy)
      else $error("final transfer without emptied store");

   a_emit_has_best: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> best_valid_ff && !used_ff[best_idx_ff])
      else $error("emit without an unused selected record");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_PROCS))
      else $error("record count beyond store depth");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_EMIT || $past(state_ff) == ST_DIV_T)
      else $error("result transfer from unexpected state");
`endif

endmodule

### sv/powt_div.sv
// ----------------------------------------------------------------------------
// powt_div
// Restoring divider, one quotient bit per cycle; done pulses when the
// quotient register holds the result.
// ----------------------------------------------------------------------------
module powt_div import powt_pkg::*; #(
   parameter int CNT_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);

   localparam int ITER_W = $clog2(DIVD_W);

   logic              busy_ff;
   logic              done_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [DIVD_W-1:0] quo_ff;

   logic [CNT_W:0]    rem_shift;
   logic              take;
   logic [CNT_W-1:0]  rem_in;

   assign rem_shift = {rem_ff, quo_ff[DIVD_W-1]};
   assign take      = rem_shift >= {1'b0, divisor};
   assign rem_in    = take ? CNT_W'(rem_shift - {1'b0, divisor}) : CNT_W'(rem_shift);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quo_ff  <= {quo_ff[DIVD_W-2:0], take};
            iter_ff <= iter_ff + 1'b1;
            if (iter_ff == ITER_W'(DIVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for priority_order_wait_times. Process records go in
// through the start/busy command port. A table of directed records covers
// the field extremes, priority ties, zero bursts and a store overflow. It is
// followed by random record sets with bursty pacing. Every schedule is
// predicted in the bench: stable sort by priority, running waits,
// turnarounds and fixed point averages. Each rsp_strobe transfer is checked
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb;
   import powt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPROC     = MAX_PROCS_DEF;
   localparam int LIMIT     = 400000;

   typedef struct packed {
      logic [ID_W-1:0]    pid;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
      logic [TIME_W-1:0]  wt;
      logic [TIME_W-1:0]  tat;
      logic [AVG_W-1:0]   avg_wt;
      logic [AVG_W-1:0]   avg_tat;
      logic               fin;
   } sched_res_type;

   typedef struct packed {
      logic [ID_W-1:0]    pid;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic               last;
      logic               typed;
      sched_res_type      exp;
   } dir_row_type;

   localparam sched_res_type NO_EXP = '0;

   // single-record sets carry their result inline; the rest go through the predictor
   localparam dir_row_type DIR_TAB [20] = '{
      '{8'h00, 16'h0000, 8'h00, 1'b1, 1'b1,
        '{8'h00, 8'h00, 16'h0000, 20'h0, 20'h0, 28'h0, 28'h0, 1'b1}},
      '{8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1,
        '{8'hFF, 8'hFF, 16'hFFFF, 20'h0, 20'h0FFFF, 28'h0, 28'h0FFFF00, 1'b1}},
      '{8'h01, 16'hFFFF, 8'h80, 1'b0, 1'b0, NO_EXP},
      '{8'h02, 16'h0000, 8'h10, 1'b0, 1'b0, NO_EXP},
      '{8'h03, 16'h1234, 8'h80, 1'b0, 1'b0, NO_EXP},
      '{8'h04, 16'hFFFF, 8'h00, 1'b0, 1'b0, NO_EXP},
      '{8'h05, 16'h0000, 8'hFF, 1'b0, 1'b0, NO_EXP},
      '{8'h06, 16'h0001, 8'h10, 1'b0, 1'b0, NO_EXP},
      '{8'h07, 16'hFFFF, 8'h80, 1'b0, 1'b0, NO_EXP},
      '{8'h08, 16'h00AA, 8'h00, 1'b0, 1'b0, NO_EXP},
      '{8'h09, 16'hFFFF, 8'hFF, 1'b0, 1'b0, NO_EXP},
      '{8'h0A, 16'h0000, 8'h80, 1'b0, 1'b0, NO_EXP},
      '{8'h0B, 16'h5555, 8'h10, 1'b0, 1'b0, NO_EXP},
      '{8'h0C, 16'hAAAA, 8'h7F, 1'b0, 1'b0, NO_EXP},
      '{8'h0D, 16'hFFFF, 8'h00, 1'b0, 1'b0, NO_EXP},
      '{8'h0E, 16'h0000, 8'hFF, 1'b0, 1'b0, NO_EXP},
      '{8'h0F, 16'h8000, 8'h80, 1'b0, 1'b0, NO_EXP},
      '{8'h10, 16'h7FFF, 8'h10, 1'b0, 1'b0, NO_EXP},
      // store full: both dropped, the second still closes the set
      '{8'hEE, 16'hFFFF, 8'h00, 1'b0, 1'b0, NO_EXP},
      '{8'hEF, 16'h0001, 8'h00, 1'b1, 1'b0, NO_EXP}
   };

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [ID_W-1:0]    req_process_id;
   logic [BURST_W-1:0] req_burst_time;
   logic [PRIO_W-1:0]  req_priority_req;
   logic               req_last;
   logic               rsp_strobe;
   logic [ID_W-1:0]    rsp_out_process_id;
   logic [PRIO_W-1:0]  rsp_out_priority;
   logic [BURST_W-1:0] rsp_out_burst;
   logic [TIME_W-1:0]  rsp_wait_time;
   logic [TIME_W-1:0]  rsp_turnaround_time;
   logic [AVG_W-1:0]   rsp_avg_wait;
   logic [AVG_W-1:0]   rsp_avg_turnaround;
   logic               rsp_final_res;

   rec_type       held_q [$];
   sched_res_type sched_q [$];
   int            fails = 0;
   int            cycles = 0;
   int            stored_cnt;
   int            burst_left;

   priority_order_wait_times u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_process_id      (req_process_id),
      .req_burst_time      (req_burst_time),
      .req_priority_req    (req_priority_req),
      .req_last            (req_last),
      .rsp_strobe          (rsp_strobe),
      .rsp_out_process_id  (rsp_out_process_id),
      .rsp_out_priority    (rsp_out_priority),
      .rsp_out_burst       (rsp_out_burst),
      .rsp_wait_time       (rsp_wait_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_avg_wait        (rsp_avg_wait),
      .rsp_avg_turnaround  (rsp_avg_turnaround),
      .rsp_final_res       (rsp_final_res)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // store a record; a closing record yields the whole schedule
   task automatic schedule_record(input rec_type r, input bit closes, input bit typed,
                                  input sched_res_type typed_exp);
      rec_type        order [$];
      sched_res_type  e;
      int             j;
      int unsigned    run;
      int unsigned    tat;
      int unsigned    wsum;
      int unsigned    tsum;
      logic [DIVD_W-1:0] avg;
      if (held_q.size() < NPROC) begin
         held_q.push_back(r);
         stored_cnt++;
      end
      if (!closes || held_q.size() == 0) return;
      foreach (held_q[i]) begin
         j = order.size();
         while (j > 0 && order[j-1].prio > held_q[i].prio) j--;
         order.insert(j, held_q[i]);
      end
      run  = 0;
      wsum = 0;
      tsum = 0;
      foreach (order[i]) begin
         tat      = run + order[i].burst;
         e        = '0;
         e.pid    = order[i].id;
         e.prio   = order[i].prio;
         e.burst  = order[i].burst;
         e.wt     = run[TIME_W-1:0];
         e.tat    = tat[TIME_W-1:0];
         wsum     = (wsum + e.wt) & 32'h00FF_FFFF;
         tsum     = (tsum + e.tat) & 32'h00FF_FFFF;
         run      = tat;
         if (i == order.size() - 1) begin
            avg       = {wsum[TOTAL_W-1:0], {FRAC_W{1'b0}}} / order.size();
            e.avg_wt  = avg[AVG_W-1:0];
            avg       = {tsum[TOTAL_W-1:0], {FRAC_W{1'b0}}} / order.size();
            e.avg_tat = avg[AVG_W-1:0];
            e.fin     = 1'b1;
         end
         if (!typed) sched_q.push_back(e);
      end
      if (typed) sched_q.push_back(typed_exp);
      held_q.delete();
   endtask

   task automatic push_record(input logic [ID_W-1:0] pid, input logic [BURST_W-1:0] burst,
                              input logic [PRIO_W-1:0] prio, input bit closes,
                              input bit typed, input sched_res_type typed_exp);
      rec_type r;
      r.id             = pid;
      r.burst          = burst;
      r.prio           = prio;
      start            <= 1'b1;
      req_process_id   <= pid;
      req_burst_time   <= burst;
      req_priority_req <= prio;
      req_last         <= closes;
      do @(posedge clock); while (busy);
      schedule_record(r, closes, typed, typed_exp);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) begin
         req_process_id   <= ID_W'($urandom_range(0, 255));
         req_burst_time   <= BURST_W'($urandom_range(0, 65535));
         req_priority_req <= PRIO_W'($urandom_range(0, 255));
         req_last         <= 1'($urandom_range(0, 1));
         @(posedge clock);
      end
   endtask

   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         idle_cycles($urandom_range(1, 6));
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sched_q.size() != 0) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [31:0] exp,
                                       input logic [31:0] act);
      if (exp !== act) begin
         fails++;
         $error("%s: expected %0h, actual %0h", name, exp, act);
      end
   endfunction

   always @(posedge clock) begin
      sched_res_type e;
      if (!reset && rsp_strobe) begin
         if (sched_q.size() == 0) begin
            fails++;
            $error("result transfer with none expected, id %0h", rsp_out_process_id);
         end else begin
            e = sched_q.pop_front();
            check_field("out_process_id", 32'(e.pid), 32'(rsp_out_process_id));
            check_field("out_priority", 32'(e.prio), 32'(rsp_out_priority));
            check_field("out_burst", 32'(e.burst), 32'(rsp_out_burst));
            check_field("wait_time", 32'(e.wt), 32'(rsp_wait_time));
            check_field("turnaround_time", 32'(e.tat), 32'(rsp_turnaround_time));
            check_field("avg_wait", 32'(e.avg_wt), 32'(rsp_avg_wait));
            check_field("avg_turnaround", 32'(e.avg_tat), 32'(rsp_avg_turnaround));
            check_field("final_res", 32'(e.fin), 32'(rsp_final_res));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("priority_order_wait_times test failed");
         $finish;
      end
   end

   initial begin
      int                 sel;
      int                 n;
      int                 pmode;
      int                 bmode;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
      stored_cnt       = 0;
      burst_left       = 0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_process_id   <= '0;
      req_burst_time   <= '0;
      req_priority_req <= '0;
      req_last         <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_TAB[k]) begin
         push_record(DIR_TAB[k].pid, DIR_TAB[k].burst, DIR_TAB[k].prio, DIR_TAB[k].last,
                     DIR_TAB[k].typed, DIR_TAB[k].exp);
         pace();
      end
      drain();

      stored_cnt = 0;
      while (stored_cnt < 480) begin
         sel   = $urandom_range(0, 19);
         n     = (sel < 12) ? $urandom_range(1, 4)  :
                 (sel < 17) ? $urandom_range(5, 10) :
                 (sel < 19) ? $urandom_range(11, 16) : $urandom_range(17, 20);
         pmode = $urandom_range(0, 3);
         bmode = $urandom_range(0, 3);
         for (int k = 0; k < n; k++) begin
            case (pmode)
               1: prio = PRIO_W'($urandom_range(0, 3));
               2: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               default: prio = PRIO_W'($urandom_range(0, 255));
            endcase
            case (bmode)
               1: burst = BURST_W'($urandom_range(0, 15));
               2: burst = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               default: burst = BURST_W'($urandom_range(0, 65535));
            endcase
            push_record(ID_W'($urandom_range(0, 255)), burst, prio, k == n - 1, 1'b0,
                        NO_EXP);
            if (k == n - 1 && $urandom_range(0, 9) == 0)
               drain();
            else
               pace();
         end
      end

      drain();
      repeat (400) @(posedge clock);
      if (fails == 0)
         $display("priority_order_wait_times test passed");
      else
         $display("priority_order_wait_times test failed");
      $finish;
   end

endmodule

### filelist.f
sv/powt_pkg.sv
sv/powt_div.sv
sv/priority_order_wait_times.sv
tb/sv/tb.sv
